>>> rtl/crcd_pkg.sv
// Shared types, constants and the CRC16-Modbus byte update for the packet deframer.
package crcd_pkg;

  localparam int unsigned HEADER_BYTES = 23;
  localparam int unsigned CRC_SPAN     = HEADER_BYTES - 2;

  localparam logic [7:0]  START_MARK = 8'h24;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // header byte positions
  localparam logic [15:0] IDX_OP      = 16'd1;
  localparam logic [15:0] IDX_LEN_HI  = 16'd2;
  localparam logic [15:0] IDX_LEN_LO  = 16'd3;
  localparam logic [15:0] IDX_CMD_HI  = 16'd17;
  localparam logic [15:0] IDX_CMD_LO  = 16'd18;
  localparam logic [15:0] IDX_PID     = 16'd20;
  localparam logic [15:0] IDX_CRC_LO  = 16'(CRC_SPAN);

  localparam logic [15:0] MAX_LEN_RESET = 16'd487;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEAD,
    PH_DATA,
    PH_DCRC
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_HDR_CRC,
    ST_DATA_CRC,
    ST_OVERSIZE
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  op_type;
    logic [15:0] command;
    logic [7:0]  packet_id;
    logic [15:0] payload_len;
    status_t     status;
    logic        last;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/crcd_front.sv
// Front end: hunts for the start mark, checks CRCs, captures header fields, emits results.
module crcd_front
  import crcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  output logic        push,
  output res_t        push_data
);

  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_seen, crc_low_seen_next;
  logic [7:0]  held_op, held_op_next;
  logic [15:0] held_len, held_len_next;
  logic [15:0] held_cmd, held_cmd_next;
  logic [7:0]  held_pid, held_pid_next;
  logic [15:0] max_payload_len;

  logic        accept;
  logic [15:0] crc_upd;
  logic [15:0] count_inc;
  logic        crc_match;

  assign accept    = in_valid && in_ready;
  assign crc_upd   = crc_feed(running_crc, rx_byte);
  assign count_inc = byte_count + 16'd1;
  assign crc_match = (crc_low_seen == running_crc[7:0]) && (rx_byte == running_crc[15:8]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      byte_count      <= '0;
      running_crc     <= CRC_INIT;
      crc_low_seen    <= '0;
      held_op         <= '0;
      held_len        <= '0;
      held_cmd        <= '0;
      held_pid        <= '0;
      max_payload_len <= MAX_LEN_RESET;
    end else begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      running_crc  <= running_crc_next;
      crc_low_seen <= crc_low_seen_next;
      held_op      <= held_op_next;
      held_len     <= held_len_next;
      held_cmd     <= held_cmd_next;
      held_pid     <= held_pid_next;
      if (cfg_valid) begin
        max_payload_len <= cfg_data;
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    running_crc_next  = running_crc;
    crc_low_seen_next = crc_low_seen;
    held_op_next      = held_op;
    held_len_next     = held_len;
    held_cmd_next     = held_cmd;
    held_pid_next     = held_pid;
    push              = 1'b0;
    push_data.kind        = KIND_END;
    push_data.data_byte   = 8'h00;
    push_data.op_type     = held_op;
    push_data.command     = held_cmd;
    push_data.packet_id   = held_pid;
    push_data.payload_len = held_len;
    push_data.status      = ST_OK;
    push_data.last        = 1'b1;

    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == START_MARK) begin
            running_crc_next = crc_feed(CRC_INIT, rx_byte);
            byte_count_next  = 16'd1;
            phase_next       = PH_HEAD;
          end
        end
        PH_HEAD: begin
          byte_count_next = count_inc;
          if (byte_count < IDX_CRC_LO) begin
            running_crc_next = crc_upd;
            unique case (byte_count)
              IDX_OP:     held_op_next  = rx_byte;
              IDX_LEN_HI: held_len_next = {rx_byte, held_len[7:0]};
              IDX_LEN_LO: held_len_next = {held_len[15:8], rx_byte};
              IDX_CMD_HI: held_cmd_next = {rx_byte, held_cmd[7:0]};
              IDX_CMD_LO: held_cmd_next = {held_cmd[15:8], rx_byte};
              IDX_PID:    held_pid_next = rx_byte;
              default:    ;
            endcase
          end else if (byte_count == IDX_CRC_LO) begin
            crc_low_seen_next = rx_byte;
          end else begin
            // CRC high byte closes the header
            phase_next       = PH_HUNT;
            byte_count_next  = '0;
            running_crc_next = CRC_INIT;
            if (!crc_match) begin
              push             = 1'b1;
              push_data.status = ST_HDR_CRC;
            end else if (held_len > max_payload_len) begin
              push             = 1'b1;
              push_data.status = ST_OVERSIZE;
            end else if (held_len == 16'd0) begin
              push = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          running_crc_next = crc_upd;
          byte_count_next  = count_inc;
          if (count_inc >= held_len) begin
            phase_next      = PH_DCRC;
            byte_count_next = '0;
          end
          push                = 1'b1;
          push_data.kind      = KIND_DATA;
          push_data.data_byte = rx_byte;
          push_data.last      = 1'b0;
        end
        PH_DCRC: begin
          if (byte_count == 16'd0) begin
            crc_low_seen_next = rx_byte;
            byte_count_next   = 16'd1;
          end else begin
            phase_next       = PH_HUNT;
            byte_count_next  = '0;
            running_crc_next = CRC_INIT;
            push             = 1'b1;
            push_data.status = crc_match ? ST_OK : ST_DATA_CRC;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_data_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> (held_len != 16'd0) && (byte_count < held_len))
    else $error("payload phase with empty length or count past length");
`endif

endmodule

>>> rtl/crcd_queue.sv
// Short result queue between the front end and the output stage.
module crcd_queue
  import crcd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output res_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

>>> rtl/crcd_back.sv
// Output stage: drains the queue into a registered stream beat and packs the fields.
module crcd_back
  import crcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_not_empty,
  input  res_t        q_head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  assign pop = q_not_empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {6'b000000, q_head.status, q_head.payload_len, q_head.packet_id,
                  q_head.command, q_head.op_type, q_head.data_byte};
      m_tuser <= q_head.kind;
      m_tlast <= q_head.last;
    end
  end

`ifndef SYNTH
  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_END)))
    else $error("tlast and kind disagree");
`endif

endmodule

>>> rtl/crc_framed_packet_deframer.sv
// Top level of the CRC16-Modbus framed packet deframer.
//
// Input stream (s_*): one received byte per beat. Bytes outside a frame are
// dropped until the start mark '$' begins a 23-byte header.
// Output stream (m_*): one beat per payload byte (tuser 0) as it arrives, and
// one frame-end or error beat (tuser 1, tlast 1) carrying the header fields
// and status: ok, header CRC error, data CRC error or oversize.
// Config channel (cfg_*): writes the largest accepted payload length; always
// ready, to be written only while no frame is in flight.
// Throughput: one byte per cycle while the queue is not full, set by the
// combinational bytewise CRC update in the front end. An output beat follows
// the byte that causes it through the queue write, then the output register.
// When the receiver stalls, results collect in the QUEUE_DEPTH-entry queue;
// s_tready drops only once it is full, and rises again as beats drain.
// Reset: synchronous; returns to hunting, empties the queue, drops m_tvalid
// and restores the length limit to 487.
module crc_framed_packet_deframer
  import crcd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [7:0] data_byte, [15:8] op_type, [31:16] command,
                                 // [39:32] packet_id, [55:40] payload_len,
                                 // [57:56] status, [63:58] zero
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic push, pop, q_full, q_not_empty;
  res_t push_data, q_head;

  assign s_tready  = !q_full;
  assign cfg_ready = 1'b1;

  crcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .rx_byte   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data)
  );

  crcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  crcd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule
